[src/sqi_pkg.sv]
// shared widths, types and constants of the segment / quad intersection unit
package sqi_pkg;

	// coordinate and derived arithmetic widths
	localparam int CW   = 21;            // signed Q12.8 coordinate
	localparam int EW   = CW + 1;        // quad edge component
	localparam int NW   = 2 * EW + 1;    // plane normal component
	localparam int TW   = NW + EW + 1;   // edge tangent component
	localparam int DENW = NW + CW + 2;   // n.L and n.S
	localparam int CHW  = 23;            // chunk of |num| for the split multiply
	localparam int NUMW = 3 * CHW;       // n.(p1 - S)
	localparam int MW   = NUMW + CW;     // |L| * |num|
	localparam int RW   = MW + 1;        // divider remainder
	localparam int QW   = CW + 1;        // quotient bits kept
	localparam int PW   = CW + 3;        // crossing point before clamping
	localparam int TLO  = TW / 2;        // low half of a tangent component
	localparam int EDW  = TW + PW + 4;   // edge side test dot product
	localparam int CFGW = 63;
	localparam int IDXW = 8;
	localparam int PRE_LAT = 7;          // quad setup pipeline depth
	localparam int PCW  = $clog2(PRE_LAT + 1);

	// register indexes
	localparam logic [IDXW-1:0] IDX_CORNER_ONE   = IDXW'(0);
	localparam logic [IDXW-1:0] IDX_CORNER_TWO   = IDXW'(1);
	localparam logic [IDXW-1:0] IDX_CORNER_THREE = IDXW'(2);
	localparam logic [IDXW-1:0] IDX_CORNER_FOUR  = IDXW'(3);

	// cross product component selects
	localparam int XN1 [3] = '{1, 2, 0};
	localparam int XN2 [3] = '{2, 0, 1};

	localparam logic signed [PW-1:0] PT_MAX = PW'(2 ** (CW - 1) - 1);
	localparam logic signed [PW-1:0] PT_MIN = -PW'(2 ** (CW - 1));

	typedef logic [2:0][CW-1:0] vec_t;

	// values derived from the four corners
	typedef struct packed {
		logic [2:0][NW-1:0]      n;
		logic [3:0][2:0][TW-1:0] t;
		logic [NUMW-1:0]         np0;
		logic [3:0][EDW-1:0]     c;
	} quad_t;

	// item state while it walks the divider
	typedef struct packed {
		logic [2:0][RW-1:0] rem;
		logic [2:0][QW-1:0] quo;
		logic [RW-1:0]      dvs;
		logic [2:0]         neg;
		logic               ovf;
		logic               dzero;
		vec_t               s;
		vec_t               l;
	} dstep_t;

	typedef struct packed {
		logic hit;
		vec_t pt;
	} res_t;

endpackage

[src/segment_quad_intersection_unit.sv]
// top level of the segment / convex quad intersection unit
//
// usage:
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   packed quad corners, index 0..3; other indexes are dropped. cfg_ready is
//   always high. write corners only while no item is in flight
// - after reset and after every config write, in_ready stays low
//   while the quad setup pipeline (normal, edge tangents, plane constants)
//   settles; corners reset to zero, which never hits
// - input channel (in_valid/in_ready) takes one segment per item: start point
//   and direction vector, signed Q12.8
// - output channel (out_valid/out_ready) returns one item per segment: hit flag
//   and crossing point, zero when there is no hit
// - one item per cycle sustained while the output buffer has room; the
//   quotient pipeline has 22 stages (one bit per stage, three axes)
// - a two-entry output buffer holds results while the receiver stalls; the
//   whole pipeline freezes only when that buffer is full, so the next item is
//   still accepted while one result waits
module segment_quad_intersection_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sqi_pkg::IDXW-1:0]      cfg_index,
	input  logic [sqi_pkg::CFGW-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sqi_pkg::CW-1:0] start_x,
	input  logic signed [sqi_pkg::CW-1:0] start_y,
	input  logic signed [sqi_pkg::CW-1:0] start_z,
	input  logic signed [sqi_pkg::CW-1:0] dir_x,
	input  logic signed [sqi_pkg::CW-1:0] dir_y,
	input  logic signed [sqi_pkg::CW-1:0] dir_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic signed [sqi_pkg::CW-1:0] point_x,
	output logic signed [sqi_pkg::CW-1:0] point_y,
	output logic signed [sqi_pkg::CW-1:0] point_z
);
	import sqi_pkg::*;

	// ---------------- config registers and quad setup ----------------
	logic [3:0][CFGW-1:0] corner_q;
	logic [PCW-1:0]       pre_cnt_q;
	logic                 cfg_wr;
	quad_t                quad;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q  <= '0;
			pre_cnt_q <= PCW'(PRE_LAT);
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					IDX_CORNER_ONE:   corner_q[0] <= cfg_data;
					IDX_CORNER_TWO:   corner_q[1] <= cfg_data;
					IDX_CORNER_THREE: corner_q[2] <= cfg_data;
					IDX_CORNER_FOUR:  corner_q[3] <= cfg_data;
					default: ;
				endcase
				// any write restarts the setup wait
				pre_cnt_q <= PCW'(PRE_LAT);
			end else if (pre_cnt_q != '0) begin
				pre_cnt_q <= pre_cnt_q - 1'b1;
			end
		end
	end

	sqi_precomp u_precomp (
		.clk    (clk),
		.corner (corner_q),
		.quad   (quad)
	);

	// ---------------- flow control ----------------
	logic [1:0] cnt_q;
	logic       en;
	logic       accept;

	// pipeline moves whenever the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en & (pre_cnt_q == '0);
	assign accept   = in_valid & in_ready;

	vec_t s_in, l_in;
	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign l_in[0] = dir_x;
	assign l_in[1] = dir_y;
	assign l_in[2] = dir_z;

	// ---------------- stage registers ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	vec_t s_s1, l_s1, s_s2, l_s2, s_s3, l_s3, s_s4, l_s4;
	vec_t s_s5, l_s5, s_s6, l_s6, s_s7, l_s7;
	logic signed [NW+CW-1:0] pnl_s1 [3];
	logic signed [NW+CW-1:0] pns_s1 [3];
	logic signed [DENW-1:0]  den_s2, ns_s2, den_s3;
	logic signed [NUMW-1:0]  num_s3;
	logic                    dzero_s3, dzero_s4, dzero_s5, dzero_s6, dzero_s7;
	logic [NUMW-1:0]         anum_s4;
	logic [DENW-1:0]         dm_s4, dm_s5, dm_s6;
	logic                    nneg_s4, dneg_s4;
	logic [CW+CHW-1:0]       pp_s5 [3][3];
	logic [2:0]              neg_s5, neg_s6, neg_s7;
	logic [MW-1:0]           m_s6 [3];
	logic [RW-1:0]           num2_s7 [3];
	logic [RW-1:0]           dvs_s7;

	logic [CW-1:0] al [3];
	dstep_t        d_s8_c;
	dstep_t        dpipe [QW+1];
	logic [QW:0]   dvld;

	logic                   v_b, v_e1, v_e2, v_e3;
	logic signed [PW-1:0]   pt_c [3];
	logic [2:0]             box_c;
	logic signed [PW-1:0]   pt_b [3], pt_e1 [3], pt_e2 [3], pt_e3 [3];
	logic                   box_b, box_e1, box_e2, box_e3;
	logic                   bad_b, bad_e1, bad_e2, bad_e3;
	logic signed [PW+TLO:0]      ppl_e1 [4][3];
	logic signed [PW+TW-TLO-1:0] pph_e1 [4][3];
	logic signed [EDW-1:0]       prod_e2 [4][3];
	logic signed [EDW-1:0]       dot_c [4];
	logic [3:0]                  inside_e3;

	// magnitude of each direction component
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			al[k] = l_s4[k][CW-1] ? CW'(-$signed(l_s4[k])) : l_s4[k];
		end
	end

	// divider entry: overflow means the quotient cannot fit, so the point
	// lies outside the segment box on that axis
	always_comb begin
		d_s8_c.rem   = '0;
		d_s8_c.quo   = '0;
		d_s8_c.dvs   = dvs_s7;
		d_s8_c.neg   = neg_s7;
		d_s8_c.dzero = dzero_s7;
		d_s8_c.s     = s_s7;
		d_s8_c.l     = l_s7;
		d_s8_c.ovf   = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d_s8_c.rem[k] = num2_s7[k];
			if ({1'b0, num2_s7[k][RW-1:1]} >= dvs_s7) begin
				d_s8_c.ovf = 1'b1;
			end
		end
	end

	// signed offset, crossing point and segment box test
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [PW-1:0] sq;
			logic signed [PW-1:0] lv;
			sq = $signed(PW'(dpipe[QW].quo[k]));
			if (dpipe[QW].neg[k]) begin
				sq = -sq;
			end
			lv = PW'($signed(dpipe[QW].l[k]));
			pt_c[k] = PW'($signed(dpipe[QW].s[k])) + sq;
			if (lv >= 0) begin
				box_c[k] = (sq >= 0) && (sq <= lv);
			end else begin
				box_c[k] = (sq <= 0) && (sq >= lv);
			end
		end
	end

	// side of each edge: (P - pk).tk = t.P - t.pk
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dot_c[k] = prod_e2[k][0] + prod_e2[k][1] + prod_e2[k][2] - $signed(quad.c[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dvld[0] <= 1'b0;
			v_b  <= 1'b0;
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			dvld[0] <= v_s7;
			v_b  <= dvld[QW];
			v_e1 <= v_b;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: n*L and n*S per axis
			s_s1 <= s_in;
			l_s1 <= l_in;
			for (int k = 0; k < 3; k++) begin
				pnl_s1[k] <= $signed(quad.n[k]) * $signed(l_in[k]);
				pns_s1[k] <= $signed(quad.n[k]) * $signed(s_in[k]);
			end
			// s2: dot products
			s_s2   <= s_s1;
			l_s2   <= l_s1;
			den_s2 <= DENW'(pnl_s1[0]) + DENW'(pnl_s1[1]) + DENW'(pnl_s1[2]);
			ns_s2  <= DENW'(pns_s1[0]) + DENW'(pns_s1[1]) + DENW'(pns_s1[2]);
			// s3: numerator n.(p1 - S)
			s_s3     <= s_s2;
			l_s3     <= l_s2;
			den_s3   <= den_s2;
			num_s3   <= $signed(quad.np0) - NUMW'(ns_s2);
			dzero_s3 <= (den_s2 == '0);
			// s4: magnitudes and signs
			s_s4     <= s_s3;
			l_s4     <= l_s3;
			anum_s4  <= num_s3[NUMW-1] ? NUMW'(-num_s3) : NUMW'(num_s3);
			nneg_s4  <= num_s3[NUMW-1];
			dm_s4    <= den_s3[DENW-1] ? DENW'(-den_s3) : DENW'(den_s3);
			dneg_s4  <= den_s3[DENW-1];
			dzero_s4 <= dzero_s3;
			// s5: |L| * |num| as partial products
			s_s5     <= s_s4;
			l_s5     <= l_s4;
			dm_s5    <= dm_s4;
			dzero_s5 <= dzero_s4;
			for (int k = 0; k < 3; k++) begin
				neg_s5[k] <= l_s4[k][CW-1] ^ nneg_s4 ^ dneg_s4;
				for (int j = 0; j < 3; j++) begin
					pp_s5[k][j] <= (CW+CHW)'(al[k]) * (CW+CHW)'(anum_s4[j*CHW +: CHW]);
				end
			end
			// s6: partial product sum
			s_s6     <= s_s5;
			l_s6     <= l_s5;
			dm_s6    <= dm_s5;
			neg_s6   <= neg_s5;
			dzero_s6 <= dzero_s5;
			for (int k = 0; k < 3; k++) begin
				m_s6[k] <= MW'(pp_s5[k][0]) + (MW'(pp_s5[k][1]) << CHW)
					+ (MW'(pp_s5[k][2]) << (2 * CHW));
			end
			// s7: round to nearest, ties away from zero: (2m + d) / 2d
			s_s7     <= s_s6;
			l_s7     <= l_s6;
			neg_s7   <= neg_s6;
			dzero_s7 <= dzero_s6;
			dvs_s7   <= RW'(dm_s6) << QW;
			for (int k = 0; k < 3; k++) begin
				num2_s7[k] <= (RW'(m_s6[k]) << 1) + RW'(dm_s6);
			end
			// s8: divider entry
			dpipe[0] <= d_s8_c;
			// point and box check
			box_b <= &box_c;
			bad_b <= dpipe[QW].dzero | dpipe[QW].ovf;
			for (int k = 0; k < 3; k++) begin
				pt_b[k] <= pt_c[k];
			end
			// e1: tangent products split in halves
			box_e1 <= box_b;
			bad_e1 <= bad_b;
			for (int c = 0; c < 3; c++) begin
				pt_e1[c] <= pt_b[c];
			end
			for (int k = 0; k < 4; k++) begin
				for (int c = 0; c < 3; c++) begin
					ppl_e1[k][c] <= pt_b[c] * $signed({1'b0, quad.t[k][c][TLO-1:0]});
					pph_e1[k][c] <= pt_b[c] * $signed(quad.t[k][c][TW-1:TLO]);
				end
			end
			// e2: recombine halves
			box_e2 <= box_e1;
			bad_e2 <= bad_e1;
			for (int c = 0; c < 3; c++) begin
				pt_e2[c] <= pt_e1[c];
			end
			for (int k = 0; k < 4; k++) begin
				for (int c = 0; c < 3; c++) begin
					prod_e2[k][c] <= (EDW'(pph_e1[k][c]) <<< TLO) + EDW'(ppl_e1[k][c]);
				end
			end
			// e3: on an edge counts as inside
			box_e3 <= box_e2;
			bad_e3 <= bad_e2;
			for (int c = 0; c < 3; c++) begin
				pt_e3[c] <= pt_e2[c];
			end
			for (int k = 0; k < 4; k++) begin
				inside_e3[k] <= ~dot_c[k][EDW-1];
			end
		end
	end

	// quotient pipeline, one bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		sqi_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dvld[i]),
			.d_i    (dpipe[i]),
			.vld_o  (dvld[i+1]),
			.d_o    (dpipe[i+1])
		);
	end

	// ---------------- result and output buffer ----------------
	res_t res_c;
	res_t buf_q [2];
	logic wr_q, rd_q;
	logic push, pop;

	always_comb begin
		res_c.hit = ~bad_e3 & box_e3 & (&inside_e3);
		for (int c = 0; c < 3; c++) begin
			logic signed [PW-1:0] v;
			v = pt_e3[c];
			if (v > PT_MAX) begin
				v = PT_MAX;
			end
			if (v < PT_MIN) begin
				v = PT_MIN;
			end
			res_c.pt[c] = res_c.hit ? CW'(v) : '0;
		end
	end

	assign push = v_e3 & en;
	assign pop  = (cnt_q != 2'd0) & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_c;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign hit       = buf_q[rd_q].hit;
	assign point_x   = $signed(buf_q[rd_q].pt[0]);
	assign point_y   = $signed(buf_q[rd_q].pt[1]);
	assign point_z   = $signed(buf_q[rd_q].pt[2]);

	// ---------------- assertions ----------------
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("input accepted while quad setup settles");

	a_miss_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (point_x == '0 && point_y == '0 && point_z == '0))
		else $error("missed segment carries a nonzero point");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_e3 && !en) |=> (v_e3 && $stable(pt_e3[0]) && $stable(inside_e3)))
		else $error("last stage item lost during stall");

endmodule

[src/sqi_precomp.sv]
// quad setup pipeline: normal, edge tangents and plane constants from the corners
module sqi_precomp (
	input  logic                              clk,
	input  logic [3:0][sqi_pkg::CFGW-1:0]     corner,
	output sqi_pkg::quad_t                    quad
);
	import sqi_pkg::*;

	logic [3:0][2:0][CW-1:0] p;

	logic signed [EW-1:0]       e_s1   [4][3];
	logic signed [2*EW-1:0]     npa_s2 [3];
	logic signed [2*EW-1:0]     npb_s2 [3];
	logic signed [NW-1:0]       n_s3   [3];
	logic signed [NW+EW-1:0]    tpa_s4 [4][3];
	logic signed [NW+EW-1:0]    tpb_s4 [4][3];
	logic signed [NW+CW-1:0]    np0p_s4 [3];
	logic signed [TW-1:0]       t_s5   [4][3];
	logic signed [NUMW-1:0]     np0_s5;
	logic signed [CW+TLO:0]     cl_s6  [4][3];
	logic signed [CW+TW-TLO-1:0] ch_s6 [4][3];
	logic signed [EDW-1:0]      c_s7   [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 3; c++) begin
				p[k][c] = corner[k][c*CW +: CW];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 3; c++) begin
				e_s1[k][c] <= EW'($signed(p[(k + 1) & 3][c])) - EW'($signed(p[k][c]));
			end
		end
		// normal from the first and second edges
		for (int c = 0; c < 3; c++) begin
			npa_s2[c] <= e_s1[0][XN1[c]] * e_s1[1][XN2[c]];
			npb_s2[c] <= e_s1[0][XN2[c]] * e_s1[1][XN1[c]];
			n_s3[c]   <= NW'(npa_s2[c]) - NW'(npb_s2[c]);
			np0p_s4[c] <= n_s3[c] * $signed(p[0][c]);
		end
		// edge tangents t = n x e
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 3; c++) begin
				tpa_s4[k][c] <= n_s3[XN1[c]] * e_s1[k][XN2[c]];
				tpb_s4[k][c] <= n_s3[XN2[c]] * e_s1[k][XN1[c]];
				t_s5[k][c]   <= TW'(tpa_s4[k][c]) - TW'(tpb_s4[k][c]);
				cl_s6[k][c]  <= $signed(p[k][c]) * $signed({1'b0, t_s5[k][c][TLO-1:0]});
				ch_s6[k][c]  <= $signed(p[k][c]) * $signed(t_s5[k][c][TW-1:TLO]);
			end
			c_s7[k] <= (EDW'(ch_s6[k][0]) <<< TLO) + EDW'(cl_s6[k][0])
				+ (EDW'(ch_s6[k][1]) <<< TLO) + EDW'(cl_s6[k][1])
				+ (EDW'(ch_s6[k][2]) <<< TLO) + EDW'(cl_s6[k][2]);
		end
		np0_s5 <= NUMW'(np0p_s4[0]) + NUMW'(np0p_s4[1]) + NUMW'(np0p_s4[2]);
	end

	always_comb begin
		quad.np0 = np0_s5;
		for (int c = 0; c < 3; c++) begin
			quad.n[c] = n_s3[c];
		end
		for (int k = 0; k < 4; k++) begin
			quad.c[k] = c_s7[k];
			for (int c = 0; c < 3; c++) begin
				quad.t[k][c] = t_s5[k][c];
			end
		end
	end

endmodule

[src/sqi_div_step.sv]
// one restoring division step for all three axes, registered
module sqi_div_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  sqi_pkg::dstep_t d_i,
	output logic            vld_o,
	output sqi_pkg::dstep_t d_o
);
	import sqi_pkg::*;

	dstep_t nxt;

	always_comb begin
		nxt = d_i;
		for (int k = 0; k < 3; k++) begin
			if (d_i.rem[k] >= d_i.dvs) begin
				nxt.rem[k] = (d_i.rem[k] - d_i.dvs) << 1;
				nxt.quo[k] = {d_i.quo[k][QW-2:0], 1'b1};
			end else begin
				nxt.rem[k] = d_i.rem[k] << 1;
				nxt.quo[k] = {d_i.quo[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule

[bench/tb_segment_quad_intersection_unit.sv]
// self-checking testbench of the segment / convex quad intersection unit
`timescale 1ns / 100ps

module tb_segment_quad_intersection_unit;
	import sqi_pkg::*;

	typedef logic signed [191:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;

	// one result item as the block should return it
	typedef struct {
		logic   hit;
		coord_t px;
		coord_t py;
		coord_t pz;
	} crossing_t;

	// exact crossing predictor plus the queue of crossings still owed by the block
	class crossing_scoreboard;
		logic [CFGW-1:0] corner [4];
		crossing_t       owed [$];
		int              mismatches;

		function new();
			foreach (corner[i]) corner[i] = '0;
			mismatches = 0;
		endfunction

		function void set_corner(logic [IDXW-1:0] idx, logic [CFGW-1:0] val);
			if (idx == IDX_CORNER_ONE) corner[0] = val;
			else if (idx == IDX_CORNER_TWO) corner[1] = val;
			else if (idx == IDX_CORNER_THREE) corner[2] = val;
			else if (idx == IDX_CORNER_FOUR) corner[3] = val;
		endfunction

		function wide_t widen(logic [CW-1:0] v);
			return {{(192-CW){v[CW-1]}}, v};
		endfunction

		function void cross3(input wide_t a [3], input wide_t b [3], output wide_t r [3]);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		// work out the crossing for one accepted segment and queue it
		function void note_segment(coord_t sx, coord_t sy, coord_t sz,
				coord_t lx, coord_t ly, coord_t lz);
			wide_t     s [3], l [3], e [3], n [3], pt [3], t [3], d [3];
			wide_t     p [4][3], ed [4][3];
			wide_t     den, num, prod, m, dm, q, lo, hi, dot;
			wide_t     hi_lim, lo_lim;
			logic      miss;
			crossing_t r;
			s[0] = widen(sx); s[1] = widen(sy); s[2] = widen(sz);
			l[0] = widen(lx); l[1] = widen(ly); l[2] = widen(lz);
			for (int k = 0; k < 3; k++) e[k] = s[k] + l[k];
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 3; k++) p[c][k] = widen(corner[c][k*CW +: CW]);
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 3; k++) ed[c][k] = p[(c + 1) % 4][k] - p[c][k];
			cross3(ed[0], ed[1], n);
			den = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
			num = n[0] * (p[0][0] - s[0]) + n[1] * (p[0][1] - s[1]) + n[2] * (p[0][2] - s[2]);
			r = '{hit: 1'b0, px: '0, py: '0, pz: '0};
			miss = (den == 0);
			if (!miss) begin
				dm = (den < 0) ? -den : den;
				for (int k = 0; k < 3; k++) begin
					prod = l[k] * num;
					m = (prod < 0) ? -prod : prod;
					// rounded to nearest, ties away from zero
					q = (2 * m + dm) / (2 * dm);
					if ((prod < 0) != (den < 0)) q = -q;
					pt[k] = s[k] + q;
				end
				// inside the segment's box on every axis, bounds included
				for (int k = 0; k < 3; k++) begin
					lo = (e[k] < s[k]) ? e[k] : s[k];
					hi = (e[k] < s[k]) ? s[k] : e[k];
					if (pt[k] < lo || pt[k] > hi) miss = 1'b1;
				end
				// inner side of every edge, edge itself counts as inside
				for (int c = 0; c < 4; c++) begin
					cross3(n, ed[c], t);
					for (int k = 0; k < 3; k++) d[k] = pt[k] - p[c][k];
					dot = d[0] * t[0] + d[1] * t[1] + d[2] * t[2];
					if (dot < 0) miss = 1'b1;
				end
			end
			if (!miss) begin
				hi_lim = (192'sd1 <<< (CW - 1)) - 1;
				lo_lim = -(192'sd1 <<< (CW - 1));
				for (int k = 0; k < 3; k++) begin
					if (pt[k] > hi_lim) pt[k] = hi_lim;
					if (pt[k] < lo_lim) pt[k] = lo_lim;
				end
				r = '{hit: 1'b1, px: pt[0][CW-1:0], py: pt[1][CW-1:0], pz: pt[2][CW-1:0]};
			end
			owed.push_back(r);
		endfunction

		function void check_crossing(logic h, coord_t x, coord_t y, coord_t z);
			crossing_t w;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: hit %0b point %0d %0d %0d", h, x, y, z);
				return;
			end
			w = owed.pop_front();
			if (h !== w.hit || x !== w.px || y !== w.py || z !== w.pz) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected hit %0b point %0d %0d %0d, got %0b %0d %0d %0d",
						w.hit, w.px, w.py, w.pz, h, x, y, z);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [IDXW-1:0] cfg_index;
	logic [CFGW-1:0] cfg_data;
	logic            in_valid;
	logic            in_ready;
	coord_t          start_x, start_y, start_z, dir_x, dir_y, dir_z;
	logic            out_valid;
	logic            out_ready;
	logic            hit;
	coord_t          point_x, point_y, point_z;

	crossing_scoreboard sb = new();
	logic   calm;        // no idling on either side while set
	int     quiet_cycles;
	coord_t quad [4][3]; // current corners, for aiming segments

	segment_quad_intersection_unit uut (.*);

	always #5 clk = ~clk;

	// receiver: stalls at random with a chance of about 8 percent, never while calm
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// result monitor, samples pre-edge values
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_crossing(hit, point_x, point_y, point_z);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [CFGW-1:0] pack(coord_t x, coord_t y, coord_t z);
		return {z, y, x};
	endfunction

	// corner write; lowers valid again before returning, so writes never overlap
	task automatic write_reg(logic [IDXW-1:0] idx, logic [CFGW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_corner(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_quad(coord_t c [4][3]);
		quad = c;
		write_reg(IDX_CORNER_ONE,   pack(c[0][0], c[0][1], c[0][2]));
		write_reg(IDX_CORNER_TWO,   pack(c[1][0], c[1][1], c[1][2]));
		write_reg(IDX_CORNER_THREE, pack(c[2][0], c[2][1], c[2][2]));
		write_reg(IDX_CORNER_FOUR,  pack(c[3][0], c[3][1], c[3][2]));
	endtask

	task automatic send_segment(coord_t sx, coord_t sy, coord_t sz,
			coord_t lx, coord_t ly, coord_t lz);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx; start_y <= sy; start_z <= sz;
		dir_x <= lx; dir_y <= ly; dir_z <= lz;
		do @(posedge clk); while (!in_ready);
		sb.note_segment(sx, sy, sz, lx, ly, lz);
	endtask

	// sender holds off until every owed crossing is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// segment aimed at a point inside the quad (or a corner), sometimes falling short
	task automatic aimed_segment(int span, bit at_corner);
		int     w [4];
		int     tot, c;
		longint tgt [3], st [3], dv;
		coord_t d [3];
		tot = 0;
		foreach (w[i]) begin
			w[i] = $urandom_range(0, 64);
			tot += w[i];
		end
		if (tot == 0) begin
			w[0] = 1;
			tot = 1;
		end
		c = $urandom_range(0, 3);
		for (int k = 0; k < 3; k++) begin
			if (at_corner) begin
				tgt[k] = quad[c][k];
			end else begin
				tgt[k] = 0;
				for (int i = 0; i < 4; i++) tgt[k] += longint'(quad[i][k]) * w[i];
				tgt[k] = tgt[k] / tot;
			end
			st[k] = tgt[k] + $signed($urandom_range(0, 2 * span)) - span;
		end
		// factor 1 ends right on the plane, 2 goes through, short stops before it
		case ($urandom_range(0, 3))
			0: for (int k = 0; k < 3; k++) d[k] = coord_t'(tgt[k] - st[k]);
			1: for (int k = 0; k < 3; k++) d[k] = coord_t'((tgt[k] - st[k]) / 2);
			default: for (int k = 0; k < 3; k++) d[k] = coord_t'(2 * (tgt[k] - st[k]));
		endcase
		send_segment(coord_t'(st[0]), coord_t'(st[1]), coord_t'(st[2]), d[0], d[1], d[2]);
	endtask

	task automatic noise_segment();
		send_segment(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
	endtask

	// direction along the first edge lies in the plane
	task automatic parallel_segment();
		send_segment(coord_t'($urandom_range(0, 4095)), coord_t'($urandom_range(0, 4095)),
			coord_t'($urandom_range(0, 4095)), quad[1][0] - quad[0][0],
			quad[1][1] - quad[0][1], quad[1][2] - quad[0][2]);
	endtask

	task automatic random_phase(int count, int span);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 70) aimed_segment(span, $urandom_range(0, 15) == 0);
			else if (r < 90) noise_segment();
			else parallel_segment();
		end
	endtask

	localparam coord_t CMAX = coord_t'(2 ** (CW - 1) - 1);
	localparam coord_t CMIN = coord_t'(-(2 ** (CW - 1)));

	initial begin
		coord_t q [4][3];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		start_x = '0; start_y = '0; start_z = '0;
		dir_x = '0; dir_y = '0; dir_z = '0;
		calm = 1'b0;
		quiet_cycles = 0;
		foreach (quad[i, k]) quad[i][k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners all zero after reset: nothing can hit
		send_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
		send_segment(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
		noise_segment();
		drain();

		// square in the z = 0 plane
		q = '{'{-4096, -4096, 0}, '{4096, -4096, 0}, '{4096, 4096, 0}, '{-4096, 4096, 0}};
		load_quad(q);
		send_segment(0, 0, 1024, 0, 0, -2048);          // through the middle
		send_segment(0, 0, 1024, 0, 0, -1024);          // ends exactly on the plane
		send_segment(0, 0, 1024, 0, 0, -512);           // stops short of the plane
		send_segment(4096, 4096, 256, 0, 0, -512);      // through a corner
		send_segment(4096, 0, -256, 0, 0, 512);         // on an edge, upward
		send_segment(4097, 0, 256, 0, 0, -512);         // just outside an edge
		send_segment(100, 200, 300, 7, -9, 0);          // parallel to the plane
		send_segment(100, 200, 300, 0, 0, 0);           // zero direction
		send_segment(-3, 5, 3, 2, -2, -9);              // rounding of the offset
		send_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		send_segment(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
		drain();

		// writes to indexes past the corners are dropped
		write_reg(IDXW'(4), {CFGW{1'b1}});
		write_reg({IDXW{1'b1}}, {CFGW{1'b1}});
		send_segment(0, 0, 1024, 0, 0, -2048);
		drain();

		// degenerate quad: first three corners collinear
		q = '{'{0, 0, 0}, '{100, 100, 100}, '{200, 200, 200}, '{50, 0, 7}};
		load_quad(q);
		random_phase(40, 1 << 16);
		drain();

		// largest quad, corners at the extremes of the range
		q = '{'{CMIN, CMIN, CMIN}, '{CMAX, CMIN, 0}, '{CMAX, CMAX, CMAX}, '{CMIN, CMAX, 0}};
		load_quad(q);
		random_phase(150, 1 << 19);
		drain();

		// calm stretch on a tilted quad
		q = '{'{-9000, -7000, -3000}, '{8000, -6000, 2000},
			'{7000, 9000, 5000}, '{-8000, 6000, 0}};
		load_quad(q);
		calm = 1'b1;
		random_phase(400, 1 << 16);
		calm = 1'b0;
		drain();

		// nonplanar quad with full-range bits in the corners
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 3; k++) q[i][k] = coord_t'($urandom);
		load_quad(q);
		random_phase(150, 1 << 18);
		drain();

		// random convex-ish quads, small to mid sized
		for (int ph = 0; ph < 8; ph++) begin
			int cx, cy, cz, r;
			cx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			cy = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			cz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			r = $urandom_range(16, 1 << 16);
			q[0] = '{coord_t'(cx - r), coord_t'(cy - r), coord_t'(cz + $urandom_range(0, r))};
			q[1] = '{coord_t'(cx + r), coord_t'(cy - r), coord_t'(cz)};
			q[2] = '{coord_t'(cx + r), coord_t'(cy + r), coord_t'(cz - $urandom_range(0, r))};
			q[3] = '{coord_t'(cx - r), coord_t'(cy + r), coord_t'(cz)};
			// for a planar quad, take the fourth corner from the other three
			for (int k = 0; k < 3; k++) q[3][k] = q[0][k] + q[2][k] - q[1][k];
			if (ph[0]) q = '{q[3], q[2], q[1], q[0]};   // opposite winding
			load_quad(q);
			random_phase(160, 1 << 16);
			drain();
		end

		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
